FILE: rtl/vftr_pkg.sv
// ----------------------------------------------------------------------------
// vftr_pkg
// Shared types and constants of the velocity faded trail ring.
// ----------------------------------------------------------------------------
package vftr_pkg;

    // default number of quads (vertex pairs) kept in the ring
    localparam int QUADS_DEF = 32;

    // 0.7 in Q0.16
    localparam logic [15:0] SEVEN_TENTHS = 16'd45875;
    // 0.001 s in Q16.16, rounded
    localparam logic [31:0] TIME_GUARD = 32'd66;
    // 1.0 in Q0.16
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [23:0] SPEED_LOW_RST  = 24'd163840;
    localparam logic [23:0] SPEED_HIGH_RST = 24'd2621440;

    // final root counter value and the step counts of the two divisions
    localparam logic [5:0] SQRT_LAST  = 6'd32;
    localparam logic [4:0] DIV1_STEPS = 5'd24;
    localparam logic [4:0] DIV2_STEPS = 5'd17;

    typedef enum logic {
        CFG_SPEED_LOW  = 1'b0,
        CFG_SPEED_HIGH = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        KIND_START  = 1'b0,
        KIND_SAMPLE = 1'b1
    } t_kind;

    // one classified sample handed from front to back
    typedef struct packed {
        logic        start;
        logic [31:0] base_x;
        logic [31:0] base_y;
        logic [31:0] base_z;
        logic [31:0] tip_x;
        logic [31:0] tip_y;
        logic [31:0] tip_z;
        logic [16:0] scale;
    } t_sample;

    // divider request and response
    typedef struct packed {
        logic        go;
        logic [31:0] rem0;
        logic [23:0] bits;
        logic [4:0]  steps;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [23:0] quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        F_IDLE,
        F_DIFF,
        F_SQUARE,
        F_ROOT,
        F_SPEED,
        F_SPEED_WAIT,
        F_SCALE,
        F_SCALE_WAIT,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_WRITE,
        B_EMIT
    } t_back_state;

endpackage

FILE: rtl/vftr_div.sv
// ----------------------------------------------------------------------------
// vftr_div
// Restoring divider, one quotient bit per cycle. The caller loads a partial
// remainder below the divisor and the remaining numerator bits, MSB first.
// ----------------------------------------------------------------------------
module vftr_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vftr_pkg::t_div_req  i_req,
    output vftr_pkg::t_div_rsp  o_rsp
);
    import vftr_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_left;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [23:0] r_bits;
    logic [23:0] r_quot;
    logic [32:0] w_shift;
    logic        w_ge;

    // trial subtract of the shifted remainder
    assign w_shift = {r_rem, r_bits[23]};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_left <= i_req.steps;
            end else if (r_busy) begin
                r_left <= r_left - 5'd1;
                if (r_left == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem  <= i_req.rem0;
            r_bits <= i_req.bits;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? 32'(w_shift - {1'b0, r_den}) : w_shift[31:0];
            r_bits <= {r_bits[22:0], 1'b0};
            r_quot <= {r_quot[22:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

FILE: rtl/vftr_front.sv
// ----------------------------------------------------------------------------
// vftr_front
// Takes a sample, forms the tip, measures distance and elapsed time, and
// turns the speed into a Q0.16 scale. Hands the result to the queue.
// ----------------------------------------------------------------------------
module vftr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_kind,
    input  logic [31:0]         i_sample_time,
    input  logic signed [31:0]  i_base_x,
    input  logic signed [31:0]  i_base_y,
    input  logic signed [31:0]  i_base_z,
    input  logic signed [17:0]  i_axis_x,
    input  logic signed [17:0]  i_axis_y,
    input  logic signed [17:0]  i_axis_z,
    input  logic [23:0]         i_speed_low,
    input  logic [23:0]         i_speed_high,
    output logic                o_push,
    output vftr_pkg::t_sample   o_sample,
    input  logic                i_full
);
    import vftr_pkg::*;

    t_front_state r_state, n_state;

    logic        r_start;
    logic [31:0] r_time;
    logic [31:0] r_base_x, r_base_y, r_base_z;
    logic [31:0] r_tip_x, r_tip_y, r_tip_z;
    logic [31:0] r_prev_x, r_prev_y, r_prev_z;
    logic [31:0] r_prev_time;
    logic [31:0] r_mag_x, r_mag_y, r_mag_z;
    logic signed [32:0] r_dt;
    logic [5:0]  r_cnt;
    logic [63:0] r_prod;
    logic [65:0] r_sum;
    logic [35:0] r_rem;
    logic [33:0] r_root;
    logic [24:0] r_speed;
    logic [16:0] r_scale;

    t_div_req    w_req;
    t_div_rsp    w_rsp;
    logic [31:0] w_sq_in;
    logic [37:0] w_rem_next;
    logic [37:0] w_test;
    logic        w_take;
    logic        w_dt_small;
    logic        w_sat;
    logic [23:0] w_diff;
    logic        w_accept;

    // base + floor(axis * 0.7), wrapped to 32 bits
    function automatic logic [31:0] tip_of(input logic [31:0] base,
                                           input logic signed [17:0] axis);
        logic signed [34:0] p;
        p = 35'(axis) * $signed({19'd0, SEVEN_TENTHS});
        return base + {{13{p[34]}}, p[34:16]};
    endfunction

    // |a - b| of two signed words
    function automatic logic [31:0] mag_of(input logic [31:0] a,
                                           input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? 32'(-d) : d[31:0];
    endfunction

    assign w_accept   = o_ready && i_valid;
    assign w_sq_in    = (r_cnt[1:0] == 2'd0) ? r_mag_x :
                        (r_cnt[1:0] == 2'd1) ? r_mag_y : r_mag_z;
    assign w_rem_next = {r_rem, r_sum[65:64]};
    assign w_test     = {2'b00, r_root, 2'b01};
    assign w_take     = (w_rem_next >= w_test);
    assign w_dt_small = (r_dt < $signed({1'b0, TIME_GUARD}));
    assign w_sat      = ({6'd0, r_root[33:8]} >= r_dt[31:0]);
    assign w_diff     = r_speed[23:0] - i_speed_low;

    vftr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, handshake and divider launch
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        w_req   = '0;
        unique case (r_state)
            F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = F_DIFF;
            end
            F_DIFF: n_state = F_SQUARE;
            F_SQUARE: begin
                if (r_cnt == 6'd3) n_state = F_ROOT;
            end
            F_ROOT: begin
                if (r_cnt == SQRT_LAST) n_state = F_SPEED;
            end
            F_SPEED: begin
                if (w_dt_small || w_sat) begin
                    n_state = F_SCALE;
                end else begin
                    w_req.go    = 1'b1;
                    w_req.rem0  = {6'd0, r_root[33:8]};
                    w_req.bits  = {r_root[7:0], 16'd0};
                    w_req.steps = DIV1_STEPS;
                    w_req.den   = r_dt[31:0];
                    n_state     = F_SPEED_WAIT;
                end
            end
            F_SPEED_WAIT: begin
                if (w_rsp.done) n_state = F_SCALE;
            end
            F_SCALE: begin
                if (r_speed <= {1'b0, i_speed_high} && r_speed >= {1'b0, i_speed_low}
                    && i_speed_high > i_speed_low) begin
                    w_req.go    = 1'b1;
                    w_req.rem0  = {9'd0, w_diff[23:1]};
                    w_req.bits  = {w_diff[0], 23'd0};
                    w_req.steps = DIV2_STEPS;
                    w_req.den   = {8'd0, i_speed_high - i_speed_low};
                    n_state     = F_SCALE_WAIT;
                end else begin
                    n_state = F_PUSH;
                end
            end
            F_SCALE_WAIT: begin
                if (w_rsp.done) n_state = F_PUSH;
            end
            F_PUSH: begin
                o_push = !i_full;
                if (!i_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    // previous sample, kept across items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
            r_prev_time <= '0;
        end else if (w_accept && i_kind == KIND_START) begin
            r_prev_x    <= i_base_x;
            r_prev_y    <= i_base_y;
            r_prev_z    <= i_base_z;
            r_prev_time <= i_sample_time - TIME_GUARD;
        end else if (r_state == F_DIFF) begin
            r_prev_x    <= r_base_x;
            r_prev_y    <= r_base_y;
            r_prev_z    <= r_base_z;
            r_prev_time <= r_time;
        end
    end

    // capture the item and its tip
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_start  <= (i_kind == KIND_START);
            r_time   <= i_sample_time;
            r_base_x <= i_base_x;
            r_base_y <= i_base_y;
            r_base_z <= i_base_z;
            r_tip_x  <= tip_of(i_base_x, i_axis_x);
            r_tip_y  <= tip_of(i_base_y, i_axis_y);
            r_tip_z  <= tip_of(i_base_z, i_axis_z);
        end
    end

    // distance, root and scale datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_DIFF: begin
                r_mag_x <= mag_of(r_base_x, r_prev_x);
                r_mag_y <= mag_of(r_base_y, r_prev_y);
                r_mag_z <= mag_of(r_base_z, r_prev_z);
                r_dt    <= $signed({1'b0, r_time}) - $signed({1'b0, r_prev_time});
                r_sum   <= '0;
                r_cnt   <= '0;
            end
            F_SQUARE: begin
                // multiply one axis, accumulate the previous product
                if (r_cnt != 6'd3) r_prod <= w_sq_in * w_sq_in;
                if (r_cnt != 6'd0) r_sum  <= r_sum + {2'b00, r_prod};
                r_cnt  <= (r_cnt == 6'd3) ? 6'd0 : r_cnt + 6'd1;
                r_rem  <= '0;
                r_root <= '0;
            end
            F_ROOT: begin
                // one root bit per cycle, two radicand bits in
                r_rem  <= w_take ? 36'(w_rem_next - w_test) : w_rem_next[35:0];
                r_root <= {r_root[32:0], w_take};
                r_sum  <= {r_sum[63:0], 2'b00};
                r_cnt  <= r_cnt + 6'd1;
            end
            F_SPEED: begin
                if (w_dt_small) r_speed <= '0;
                else if (w_sat) r_speed <= 25'h1000000;
            end
            F_SPEED_WAIT: begin
                if (w_rsp.done) r_speed <= {1'b0, w_rsp.quot};
            end
            F_SCALE: begin
                if (r_speed > {1'b0, i_speed_high}) r_scale <= ONE_Q16;
                else r_scale <= '0;
            end
            F_SCALE_WAIT: begin
                if (w_rsp.done) r_scale <= w_rsp.quot[16:0];
            end
            default: ;
        endcase
    end

    assign o_sample.start  = r_start;
    assign o_sample.base_x = r_base_x;
    assign o_sample.base_y = r_base_y;
    assign o_sample.base_z = r_base_z;
    assign o_sample.tip_x  = r_tip_x;
    assign o_sample.tip_y  = r_tip_y;
    assign o_sample.tip_z  = r_tip_z;
    assign o_sample.scale  = r_scale;

endmodule

FILE: rtl/vftr_queue.sv
// ----------------------------------------------------------------------------
// vftr_queue
// Two-entry queue of classified samples between front and back.
// ----------------------------------------------------------------------------
module vftr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  vftr_pkg::t_sample  i_data,
    output logic               o_full,
    input  logic               i_pop,
    output vftr_pkg::t_sample  o_data,
    output logic               o_empty
);
    import vftr_pkg::*;

    t_sample    r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_slot[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // hold the words
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_data;
    end

endmodule

FILE: rtl/vftr_back.sv
// ----------------------------------------------------------------------------
// vftr_back
// Maintains the vertex ring: writes each sample's pair, then streams every
// stored vertex in ring order with its brightness and fading opacity.
// ----------------------------------------------------------------------------
module vftr_back #(
    parameter int QUADS = vftr_pkg::QUADS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  vftr_pkg::t_sample  i_data,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [5:0]         o_vertex_number,
    output logic [31:0]        o_vert_x,
    output logic [31:0]        o_vert_y,
    output logic [31:0]        o_vert_z,
    output logic [16:0]        o_brightness,
    output logic [16:0]        o_opacity,
    output logic               o_final
);
    import vftr_pkg::*;

    localparam int SPAN = 2 * QUADS;
    localparam int AW   = $clog2(SPAN);
    localparam int SW   = AW + 1;
    localparam int PW   = $clog2(QUADS + 1);
    localparam logic [SW-1:0] SPAN_V = SW'(SPAN);

    t_back_state r_state, n_state;

    t_sample       r_rec;
    logic [AW-1:0] r_ring_start, n_ring_start;
    logic [PW-1:0] r_pair_count, n_pair_count;
    logic [AW-1:0] r_w, n_w;
    logic [1:0]    r_wcnt;
    logic [SW-1:0] r_i;
    logic [SW-1:0] r_n;

    // ring storage
    logic [31:0]   r_mem_x [SPAN];
    logic [31:0]   r_mem_y [SPAN];
    logic [31:0]   r_mem_z [SPAN];
    logic [16:0]   r_mem_s [SPAN];
    logic [SPAN-1:0] r_sv;

    // read stage
    logic          r_b_vld;
    logic [AW-1:0] r_b_i;
    logic          r_b_last;
    logic [31:0]   r_rd_x, r_rd_y, r_rd_z;
    logic [16:0]   r_rd_s;
    logic          r_rd_sv;

    // output register
    logic          r_o_vld;
    logic [5:0]    r_o_num;
    logic [31:0]   r_o_x, r_o_y, r_o_z;
    logic [16:0]   r_o_bright, r_o_opac;
    logic          r_o_last;

    logic [AW-1:0] w_ring_start_in;
    logic [PW-1:0] w_pair_count_in;
    logic [SW-1:0] w_wsum;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wx, w_wy, w_wz;
    logic          w_wr;
    logic          w_adv;
    logic          w_issue;
    logic [SW-1:0] w_pos;
    logic [AW-1:0] w_idx;
    logic [AW-1:0] w_pidx;
    logic [16:0]   w_bright;
    logic [33:0]   w_opac;
    logic [16:0]   w_fade [QUADS];

    // fade per pair: 1 - pair/QUADS in Q0.16
    for (genvar g = 0; g < QUADS; g++) begin : g_fade
        assign w_fade[g] = 17'(65536 - (g * 65536) / QUADS);
    end

    // ring pointers as seen by a new sample
    assign w_ring_start_in = i_data.start ? '0 : r_ring_start;
    assign w_pair_count_in = i_data.start ? PW'(1) : r_pair_count;
    assign w_wsum = SW'(w_ring_start_in) + SW'({w_pair_count_in, 1'b0});

    always_comb begin
        if (w_pair_count_in >= PW'(QUADS)) begin
            n_ring_start = (w_ring_start_in == '0) ? AW'(SPAN - 2)
                                                   : w_ring_start_in - AW'(2);
            n_w          = n_ring_start;
            n_pair_count = w_pair_count_in;
        end else begin
            n_ring_start = w_ring_start_in;
            n_w          = (w_wsum >= SPAN_V) ? AW'(w_wsum - SPAN_V) : AW'(w_wsum);
            n_pair_count = w_pair_count_in + PW'(1);
        end
    end

    // write step: seed pair 0 on start, then the new pair
    assign w_wr    = (r_state == B_WRITE);
    assign w_waddr = r_wcnt[1] ? (r_w + AW'(r_wcnt[0])) : AW'(r_wcnt[0]);
    assign w_wx    = r_wcnt[0] ? r_rec.tip_x : r_rec.base_x;
    assign w_wy    = r_wcnt[0] ? r_rec.tip_y : r_rec.base_y;
    assign w_wz    = r_wcnt[0] ? r_rec.tip_z : r_rec.base_z;

    // emission addressing, with the seam fix-up on positions
    assign w_adv   = !r_o_vld || i_ready;
    assign w_issue = (r_state == B_EMIT) && (r_i != r_n) && w_adv;
    assign w_pos   = r_i + SW'(r_ring_start);
    assign w_idx   = (w_pos >= SPAN_V) ? AW'(w_pos - SPAN_V) : AW'(w_pos);
    always_comb begin
        if (w_pos == SPAN_V) begin
            w_pidx = AW'(SPAN - 2);
        end else if (w_pos == SPAN_V + SW'(1)) begin
            w_pidx = AW'(SPAN - 1);
        end else begin
            w_pidx = w_idx;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and pop
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = B_WRITE;
                end
            end
            B_WRITE: begin
                if (r_wcnt == 2'd3) n_state = B_EMIT;
            end
            B_EMIT: begin
                if (r_i == r_n) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // ring control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_start <= '0;
            r_pair_count <= '0;
            r_i          <= '0;
            r_n          <= '0;
            r_wcnt       <= '0;
        end else begin
            if (o_pop) begin
                r_ring_start <= n_ring_start;
                r_pair_count <= n_pair_count;
                r_wcnt       <= i_data.start ? 2'd0 : 2'd2;
                r_i          <= '0;
                r_n          <= SW'({n_pair_count, 1'b0});
            end else if (w_wr) begin
                r_wcnt <= r_wcnt + 2'd1;
            end
            if (w_issue) r_i <= r_i + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_data;
            r_w   <= n_w;
        end
    end

    // scale valid bits: start clears, new pair sets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
        end else if (o_pop && i_data.start) begin
            r_sv <= '0;
        end else if (w_wr && r_wcnt[1]) begin
            r_sv[w_waddr] <= 1'b1;
        end
    end

    // ring memories
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem_x[w_waddr] <= w_wx;
            r_mem_y[w_waddr] <= w_wy;
            r_mem_z[w_waddr] <= w_wz;
        end
        if (w_wr && r_wcnt[1]) begin
            r_mem_s[w_waddr] <= r_rec.scale;
        end
        if (w_issue) begin
            r_rd_x  <= r_mem_x[w_pidx];
            r_rd_y  <= r_mem_y[w_pidx];
            r_rd_z  <= r_mem_z[w_pidx];
            r_rd_s  <= r_mem_s[w_idx];
            r_rd_sv <= r_sv[w_idx];
        end
    end

    // read stage tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_adv) begin
            r_b_vld <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_b_i    <= AW'(r_i);
            r_b_last <= (r_i + SW'(1) == r_n);
        end
    end

    // output register with opacity product
    assign w_bright = r_rd_sv ? r_rd_s : '0;
    assign w_opac   = w_fade[r_b_i[AW-1:1]] * w_bright;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_o_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_b_vld) begin
            r_o_num    <= 6'(r_b_i);
            r_o_x      <= r_rd_x;
            r_o_y      <= r_rd_y;
            r_o_z      <= r_rd_z;
            r_o_bright <= w_bright;
            r_o_opac   <= w_opac[32:16];
            r_o_last   <= r_b_last;
        end
    end

    assign o_valid         = r_o_vld;
    assign o_vertex_number = r_o_num;
    assign o_vert_x        = r_o_x;
    assign o_vert_y        = r_o_y;
    assign o_vert_z        = r_o_z;
    assign o_brightness    = r_o_bright;
    assign o_opacity       = r_o_opac;
    assign o_final         = r_o_last;

endmodule

FILE: rtl/velocity_faded_trail_ring.sv
// ----------------------------------------------------------------------------
// velocity_faded_trail_ring
// Motion trail vertex ring with speed-scaled, fading vertices.
// ----------------------------------------------------------------------------
// Each accepted sample writes a base/tip pair into a ring of 2*QUADS vertices
// and then streams every stored vertex in ring order from the ring start, one
// word per cycle while m_axis_tready is high, with tlast on the last vertex
// (up to 2*QUADS words per sample). The front forms an iterative square root
// of the squared distance, then uses a shared radix-2 divider for the speed
// (24 steps) and for the scale (17 steps), skipping a division when its result
// is fixed by range checks. A two-entry queue lets the
// front work on the next sample while the back is still writing and emitting
// the previous one. No clearing pass is needed after reset; the scale store
// uses per-entry valid bits. Threshold registers may only be written while
// no sample is in flight.
// ----------------------------------------------------------------------------
module velocity_faded_trail_ring #(
    parameter int QUADS = vftr_pkg::QUADS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration write channel
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [23:0]   i_cfg_data,
    // sample input
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata: sample_time[31:0], base_x[63:32], base_y[95:64], base_z[127:96],
    //        axis_x[145:128], axis_y[163:146], axis_z[181:164], zero pad
    input  logic [183:0]  s_axis_tdata,
    // tuser: kind
    input  logic          s_axis_tuser,
    // vertex output
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata: vertex_number[5:0], vert_x[37:6], vert_y[69:38], vert_z[101:70],
    //        brightness[118:102], opacity[135:119]
    output logic [135:0]  m_axis_tdata,
    output logic          m_axis_tlast
);
    import vftr_pkg::*;

    logic [23:0] r_speed_low;
    logic [23:0] r_speed_high;
    logic        w_push;
    logic        w_pop;
    logic        w_full;
    logic        w_empty;
    t_sample     w_front_sample;
    t_sample     w_back_sample;
    logic [5:0]  w_num;
    logic [31:0] w_vx, w_vy, w_vz;
    logic [16:0] w_bright, w_opac;

    // threshold registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_low  <= SPEED_LOW_RST;
            r_speed_high <= SPEED_HIGH_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SPEED_LOW:  r_speed_low  <= i_cfg_data;
                CFG_SPEED_HIGH: r_speed_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vftr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_kind        (s_axis_tuser),
        .i_sample_time (s_axis_tdata[31:0]),
        .i_base_x      (s_axis_tdata[63:32]),
        .i_base_y      (s_axis_tdata[95:64]),
        .i_base_z      (s_axis_tdata[127:96]),
        .i_axis_x      (s_axis_tdata[145:128]),
        .i_axis_y      (s_axis_tdata[163:146]),
        .i_axis_z      (s_axis_tdata[181:164]),
        .i_speed_low   (r_speed_low),
        .i_speed_high  (r_speed_high),
        .o_push        (w_push),
        .o_sample      (w_front_sample),
        .i_full        (w_full)
    );

    vftr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_sample),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_back_sample),
        .o_empty (w_empty)
    );

    vftr_back #(
        .QUADS (QUADS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (w_empty),
        .i_data          (w_back_sample),
        .o_pop           (w_pop),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_vertex_number (w_num),
        .o_vert_x        (w_vx),
        .o_vert_y        (w_vy),
        .o_vert_z        (w_vz),
        .o_brightness    (w_bright),
        .o_opacity       (w_opac),
        .o_final         (m_axis_tlast)
    );

    assign m_axis_tdata = {w_opac, w_bright, w_vz, w_vy, w_vx, w_num};

endmodule

FILE: rtl/vftr_checker.sv
// ----------------------------------------------------------------------------
// vftr_checker
// Port-level checks of the trail ring output stream.
// ----------------------------------------------------------------------------
module vftr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [135:0]  m_axis_tdata,
    input logic          m_axis_tlast
);
    logic w_acc;
    assign w_acc = m_axis_tvalid && m_axis_tready;

    // nothing is shown right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("stalled output word changed");

    // vertices of a run are numbered in order
    a_number_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !m_axis_tlast |=> !m_axis_tvalid
        || m_axis_tdata[5:0] == 6'($past(m_axis_tdata[5:0]) + 6'd1))
        else $error("vertex number skipped");

    // a new run starts at vertex zero
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && m_axis_tlast |=> !m_axis_tvalid || m_axis_tdata[5:0] == 6'd0)
        else $error("run did not start at vertex zero");

    // faded opacity never exceeds the brightness
    a_opacity_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[135:119] <= m_axis_tdata[118:102]
        && m_axis_tdata[118:102] <= 17'h10000)
        else $error("opacity above brightness");

endmodule

bind velocity_faded_trail_ring vftr_checker u_vftr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
